// ===== rtl/swmm_pkg.sv =====
// Shared types and constants for the sliding-window minimum/maximum block.
// Used by swmm_extreme_unit and sliding_window_min_max_ring; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swmm_pkg;

	// Width of the action field and layout of the slave-side tuser
	localparam int ACTION_W = 2;
	localparam int TUSER_W  = 3;
	localparam int VALID_BIT = 2;

	// Operation carried by each input transaction
	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH  = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ  = 2'd2
	} action_t;

	// Commands to the shared extreme unit
	typedef struct packed {
		logic clear;   // zero both extremes
		logic load;    // take the sample as both extremes
		logic update;  // fold the sample into the extremes
	} extreme_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/swmm_extreme_unit.sv =====
// Shared compare unit holding the running minimum and maximum of the window.
// Depends on swmm_pkg for the command struct.
`timescale 1ns / 1ps
`default_nettype none

module swmm_extreme_unit #(
	parameter int SAMPLE_WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire swmm_pkg::extreme_ctl_t   ctl,
	input  wire logic [SAMPLE_WIDTH-1:0]  sample,
	output logic      [SAMPLE_WIDTH-1:0]  low,
	output logic      [SAMPLE_WIDTH-1:0]  high
);

	logic [SAMPLE_WIDTH-1:0] low_q;
	logic [SAMPLE_WIDTH-1:0] high_q;
	logic                    below;
	logic                    above;

	// Signed compares against the held extremes
	assign below = $signed(sample) < $signed(low_q);
	assign above = $signed(sample) > $signed(high_q);

	// Hold, load or fold in the extremes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
		end else if (ctl.clear) begin
			low_q  <= '0;
			high_q <= '0;
		end else if (ctl.load) begin
			low_q  <= sample;
			high_q <= sample;
		end else if (ctl.update) begin
			if (below) begin
				low_q <= sample;
			end
			if (above) begin
				high_q <= sample;
			end
		end
	end

	assign low  = low_q;
	assign high = high_q;

endmodule

`default_nettype wire

// ===== rtl/sliding_window_min_max_ring.sv =====
// Top level of the sliding-window minimum/maximum ring buffer.
// Depends on swmm_pkg and swmm_extreme_unit.
`timescale 1ns / 1ps
`default_nettype none

// Keeps the last DEPTH signed samples in a ring memory with the running minimum
// and maximum, and answers every input transaction with one result transaction.
// Items are handled one at a time; s_tready is high only while the sequencer
// is idle. A push into a window that is not full, a clear, an ignored push or an
// unused action goes straight to the finishing step; an in-range read first
// waits on the memory read, and a push that evicts a sample which is not an
// extreme first overwrites the oldest slot. A push that evicts the minimum or
// maximum rescans the whole window through the single memory read port and
// the shared compare unit, one sample a cycle. A finished result waits in the
// output register while the next transaction is taken. The sample memory needs
// no clearing pass: only entries below the held count are ever read.
module sliding_window_min_max_ring #(
	parameter int DEPTH        = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// tdata: sample_value, read_index, zero padding
	input  wire logic [((SAMPLE_WIDTH + ((DEPTH > 1) ? $clog2(DEPTH) : 1) + 7) / 8) * 8 - 1:0]
		s_tdata,
	// tuser: action (2 bits), sample_valid
	input  wire logic [swmm_pkg::TUSER_W-1:0] s_tuser,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// tdata: window_count, window_min, window_max, newest_sample, read_sample, zero padding
	output logic [(($clog2(DEPTH + 1) + 4 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready
);

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SW    = SAMPLE_WIDTH;
	localparam int OUT_W = ((CNT_W + 4 * SW + 7) / 8) * 8;
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] LAST_POS   = CNT_W'(DEPTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVICT,
		ST_SCAN,
		ST_DRAIN,
		ST_READ_WAIT,
		ST_FINISH
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           oldest_q;
	logic [CNT_W-1:0]        count_q;
	logic [SW-1:0]           newest_q;
	logic [SW-1:0]           sample_q;
	logic [SW-1:0]           rdval_q;
	logic [AW-1:0]           scan_addr_q;
	logic [CNT_W-1:0]        scan_pos_q;
	logic                    scan_v_s1;
	logic                    scan_first_s1;
	logic [OUT_W-1:0]        m_tdata_q;
	logic                    m_tvalid_q;

	logic [SW-1:0]           mem_q [DEPTH];
	logic [SW-1:0]           rd_data_q;
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [SW-1:0]           mem_wdata;
	logic                    mem_re;
	logic [AW-1:0]           mem_raddr;

	swmm_pkg::extreme_ctl_t  ext_ctl;
	logic [SW-1:0]           ext_sample;
	logic [SW-1:0]           ext_low;
	logic [SW-1:0]           ext_high;

	swmm_pkg::action_t       in_action;
	logic                    in_valid;
	logic [SW-1:0]           in_sample;
	logic [AW-1:0]           in_index;
	logic                    accept;
	logic                    is_full;
	logic                    in_range;
	logic                    evict_hit;

	// Ring address: base plus offset, wrapped once at DEPTH
	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
		input logic [CNT_W-1:0] ofs);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(base) + {1'b0, ofs};
		if (sum >= (CNT_W + 1)'(DEPTH)) begin
			sum = sum - (CNT_W + 1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	// Unpack the input transaction
	assign in_action = swmm_pkg::action_t'(s_tuser[swmm_pkg::ACTION_W-1:0]);
	assign in_valid  = s_tuser[swmm_pkg::VALID_BIT];
	assign in_sample = s_tdata[SW-1:0];
	assign in_index  = s_tdata[SW+AW-1:SW];

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign is_full   = (count_q == FULL_COUNT);
	assign in_range  = (CNT_W'(in_index) < count_q);
	assign evict_hit = (rd_data_q == ext_low) || (rd_data_q == ext_high);

	// Steer the memory port and the extreme unit
	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = oldest_q;
		mem_wdata  = in_sample;
		mem_re     = 1'b0;
		mem_raddr  = scan_addr_q;
		ext_ctl    = '0;
		ext_sample = rd_data_q;
		unique case (state_q)
			ST_IDLE: begin
				ext_sample = in_sample;
				if (accept) begin
					case (in_action)
						swmm_pkg::ACT_PUSH: begin
							if (in_valid && count_q == '0) begin
								mem_we      = 1'b1;
								mem_waddr   = '0;
								ext_ctl.load = 1'b1;
							end else if (in_valid && !is_full) begin
								mem_we         = 1'b1;
								mem_waddr      = ring_add(oldest_q, count_q);
								ext_ctl.update = 1'b1;
							end else if (in_valid) begin
								mem_re    = 1'b1;
								mem_raddr = oldest_q;
							end
						end
						swmm_pkg::ACT_CLEAR: begin
							ext_ctl.clear = 1'b1;
						end
						swmm_pkg::ACT_READ: begin
							mem_re    = in_range;
							mem_raddr = ring_add(oldest_q, CNT_W'(in_index));
						end
						default: begin
						end
					endcase
				end
			end
			ST_EVICT: begin
				mem_we         = 1'b1;
				mem_waddr      = oldest_q;
				mem_wdata      = sample_q;
				ext_sample     = sample_q;
				ext_ctl.update = !evict_hit;
			end
			ST_SCAN: begin
				mem_re = 1'b1;
			end
			default: begin
			end
		endcase
		// Fold in rescan data in the cycle after its read
		if (scan_v_s1) begin
			ext_ctl.load   = scan_first_s1;
			ext_ctl.update = !scan_first_s1;
		end
	end

	// Sample memory: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[mem_raddr];
		end
	end

	swmm_extreme_unit #(
		.SAMPLE_WIDTH(SW)
	) u_extreme (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ext_ctl),
		.sample (ext_sample),
		.low    (ext_low),
		.high   (ext_high)
	);

	// Sequencer, window bookkeeping and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			oldest_q      <= '0;
			count_q       <= '0;
			newest_q      <= '0;
			sample_q      <= '0;
			rdval_q       <= '0;
			scan_addr_q   <= '0;
			scan_pos_q    <= '0;
			scan_v_s1     <= 1'b0;
			scan_first_s1 <= 1'b0;
			m_tdata_q     <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			scan_v_s1     <= (state_q == ST_SCAN);
			scan_first_s1 <= (scan_pos_q == '0);
			// Drop a taken result unless the finishing step replaces it
			if (m_tready && state_q != ST_FINISH) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rdval_q  <= '0;
						sample_q <= in_sample;
						case (in_action)
							swmm_pkg::ACT_PUSH: begin
								if (in_valid && count_q == '0) begin
									oldest_q <= '0;
									count_q  <= CNT_W'(1);
									newest_q <= in_sample;
									state_q  <= ST_FINISH;
								end else if (in_valid && !is_full) begin
									count_q  <= count_q + CNT_W'(1);
									newest_q <= in_sample;
									state_q  <= ST_FINISH;
								end else if (in_valid) begin
									state_q <= ST_EVICT;
								end else begin
									state_q <= ST_FINISH;
								end
							end
							swmm_pkg::ACT_CLEAR: begin
								oldest_q <= '0;
								count_q  <= '0;
								newest_q <= '0;
								state_q  <= ST_FINISH;
							end
							swmm_pkg::ACT_READ: begin
								if (in_range) begin
									state_q <= ST_READ_WAIT;
								end else begin
									state_q <= ST_FINISH;
								end
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_EVICT: begin
					// Overwrite the oldest slot; rescan if it held an extreme
					oldest_q <= ring_add(oldest_q, CNT_W'(1));
					newest_q <= sample_q;
					if (evict_hit) begin
						scan_addr_q <= ring_add(oldest_q, CNT_W'(1));
						scan_pos_q  <= '0;
						state_q     <= ST_SCAN;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_SCAN: begin
					scan_addr_q <= ring_add(scan_addr_q, CNT_W'(1));
					scan_pos_q  <= scan_pos_q + CNT_W'(1);
					if (scan_pos_q == LAST_POS) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_READ_WAIT: begin
					rdval_q <= rd_data_q;
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					// Load the result once the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= OUT_W'({rdval_q, newest_q, ext_high, ext_low, count_q});
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tdata  = m_tdata_q;
	assign m_tvalid = m_tvalid_q;

	// The window never holds more than DEPTH samples
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("held count exceeds window depth");

	// Between transactions the minimum never lies above the maximum
	a_extreme_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ($signed(ext_low) <= $signed(ext_high)))
		else $error("minimum above maximum");

	// An accepted clear empties the window
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_action == swmm_pkg::ACT_CLEAR) |=>
			(count_q == '0 && newest_q == '0 && ext_low == '0 && ext_high == '0))
		else $error("clear left samples behind");

	// A result appears only out of the finishing step
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside the finishing step");

endmodule

`default_nettype wire

// ===== verif/sliding_window_min_max_ring_tb.sv =====
// Self-checking testbench for the sliding-window minimum/maximum ring buffer.
// Depends on swmm_pkg and the sliding_window_min_max_ring RTL; reads no files.
`timescale 1ns / 1ps

module sliding_window_min_max_ring_tb;

	localparam int DEPTH     = 64;
	localparam int SAMPLE_W  = 32;
	localparam int INDEX_W   = 6;
	localparam int COUNT_W   = 7;
	localparam int IN_W      = ((SAMPLE_W + INDEX_W + 7) / 8) * 8;
	localparam int OUT_W     = ((COUNT_W + 4 * SAMPLE_W + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 700;
	localparam int LONG_HOLD    = 400;

	// Action code that the block must treat as a no-op
	localparam logic [swmm_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;

	// Window state reported by one result transaction
	typedef struct packed {
		logic [COUNT_W-1:0]  count;
		logic [SAMPLE_W-1:0] low;
		logic [SAMPLE_W-1:0] high;
		logic [SAMPLE_W-1:0] newest;
		logic [SAMPLE_W-1:0] read;
	} window_report_t;

	// One row of the directed stimulus; want is used only where typed is set
	typedef struct {
		logic [swmm_pkg::ACTION_W-1:0] act;
		logic [SAMPLE_W-1:0] value;
		logic                val_ok;
		logic [INDEX_W-1:0]  idx;
		bit                  typed;
		window_report_t      want;
	} stim_row_t;

	localparam int N_DIRECTED = 20;

	stim_row_t directed_rows [N_DIRECTED] = '{
		// read and spare action on an empty window
		'{swmm_pkg::ACT_READ,  32'h0000_0000, 1'b0, 6'd0,  1'b1, '0},
		'{ACT_SPARE,           32'hFFFF_FFFF, 1'b1, 6'd63, 1'b1, '0},
		// push without sample_valid is ignored
		'{swmm_pkg::ACT_PUSH,  32'h7FFF_FFFF, 1'b0, 6'd0,  1'b1, '0},
		// most negative, then most positive sample
		'{swmm_pkg::ACT_PUSH,  32'h8000_0000, 1'b1, 6'd0,  1'b1,
			'{7'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0}},
		'{swmm_pkg::ACT_PUSH,  32'h7FFF_FFFF, 1'b1, 6'd0,  1'b1,
			'{7'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0}},
		'{swmm_pkg::ACT_READ,  32'h0000_0000, 1'b1, 6'd0,  1'b1,
			'{7'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000}},
		'{swmm_pkg::ACT_READ,  32'h0000_0000, 1'b0, 6'd1,  1'b1,
			'{7'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}},
		// read beyond the held count
		'{swmm_pkg::ACT_READ,  32'hFFFF_FFFF, 1'b1, 6'd63, 1'b1,
			'{7'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0}},
		'{swmm_pkg::ACT_PUSH,  32'hFFFF_FFFF, 1'b1, 6'd63, 1'b1,
			'{7'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0}},
		'{swmm_pkg::ACT_PUSH,  32'h0000_1234, 1'b0, 6'd5,  1'b1,
			'{7'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0}},
		'{ACT_SPARE,           32'h0001_0000, 1'b1, 6'd1,  1'b1,
			'{7'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0}},
		'{swmm_pkg::ACT_PUSH,  32'h0000_0000, 1'b1, 6'd63, 1'b0, '0},
		'{swmm_pkg::ACT_READ,  32'h5555_AAAA, 1'b1, 6'd2,  1'b0, '0},
		// clear, then read and push into the emptied window
		'{swmm_pkg::ACT_CLEAR, 32'hAAAA_5555, 1'b1, 6'd42, 1'b1, '0},
		'{swmm_pkg::ACT_READ,  32'h0000_0000, 1'b0, 6'd0,  1'b1, '0},
		'{swmm_pkg::ACT_PUSH,  32'h0001_0000, 1'b1, 6'd21, 1'b1,
			'{7'd1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0}},
		'{swmm_pkg::ACT_PUSH,  32'hFFFF_0000, 1'b1, 6'd0,  1'b0, '0},
		'{swmm_pkg::ACT_READ,  32'h0000_0000, 1'b0, 6'd1,  1'b0, '0},
		'{swmm_pkg::ACT_CLEAR, 32'h0000_0000, 1'b0, 6'd0,  1'b1, '0},
		'{swmm_pkg::ACT_PUSH,  32'h0000_0001, 1'b1, 6'd0,  1'b0, '0}
	};

	logic              clk;
	logic              arst_n;
	logic [IN_W-1:0]   s_tdata;
	logic [swmm_pkg::TUSER_W-1:0] s_tuser;
	logic              s_tvalid;
	logic              s_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tvalid;
	logic              m_tready;

	// Predicted window contents
	logic signed [SAMPLE_W-1:0] ring [DEPTH];
	logic [INDEX_W-1:0]         ring_oldest;
	logic [COUNT_W-1:0]         ring_count;
	logic signed [SAMPLE_W-1:0] ring_low;
	logic signed [SAMPLE_W-1:0] ring_high;

	window_report_t window_reports_due [$];
	int reports_checked;
	int mismatches;
	int burst_left;
	bit long_hold_done;

	sliding_window_min_max_ring #(
		.DEPTH(DEPTH),
		.SAMPLE_WIDTH(SAMPLE_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one transaction to the predicted window and return its report
	function automatic window_report_t step_window(
			input logic [swmm_pkg::ACTION_W-1:0] act,
			input logic signed [SAMPLE_W-1:0] value, input logic val_ok,
			input logic [INDEX_W-1:0] idx);
		window_report_t rep;
		logic [INDEX_W-1:0] slot;
		logic signed [SAMPLE_W-1:0] evicted;
		rep = '0;
		if (act == swmm_pkg::ACT_PUSH && val_ok) begin
			if (ring_count == 0) begin
				ring_oldest = '0;
				ring[0] = value;
				ring_count = COUNT_W'(1);
				ring_low = value;
				ring_high = value;
			end else if (ring_count < DEPTH) begin
				slot = ring_oldest + ring_count[INDEX_W-1:0];
				ring[slot] = value;
				ring_count = ring_count + 1'b1;
				if (value < ring_low) ring_low = value;
				if (value > ring_high) ring_high = value;
			end else begin
				// full: overwrite the oldest and rescan if it held an extreme
				slot = ring_oldest;
				evicted = ring[slot];
				ring[slot] = value;
				ring_oldest = slot + 1'b1;
				if (evicted == ring_low || evicted == ring_high) begin
					ring_low = ring[ring_oldest];
					ring_high = ring_low;
					for (int i = 1; i < ring_count; i++) begin
						slot = ring_oldest + INDEX_W'(i);
						if (ring[slot] < ring_low) ring_low = ring[slot];
						if (ring[slot] > ring_high) ring_high = ring[slot];
					end
				end else begin
					if (value < ring_low) ring_low = value;
					if (value > ring_high) ring_high = value;
				end
			end
		end else if (act == swmm_pkg::ACT_CLEAR) begin
			ring_oldest = '0;
			ring_count = '0;
			ring_low = '0;
			ring_high = '0;
		end else if (act == swmm_pkg::ACT_READ && {1'b0, idx} < ring_count) begin
			slot = ring_oldest + idx;
			rep.read = ring[slot];
		end
		rep.count = ring_count;
		if (ring_count != 0) begin
			slot = ring_oldest + ring_count[INDEX_W-1:0] - 1'b1;
			rep.low = ring_low;
			rep.high = ring_high;
			rep.newest = ring[slot];
		end
		return rep;
	endfunction

	// Offer one transaction in the sender's burst pattern and log its report
	task automatic issue(input logic [swmm_pkg::ACTION_W-1:0] act,
			input logic [SAMPLE_W-1:0] value,
			input logic val_ok, input logic [INDEX_W-1:0] idx, input bit typed,
			input window_report_t typed_report);
		window_report_t predicted;
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W - SAMPLE_W - INDEX_W){1'b0}}, idx, value};
		s_tuser <= {val_ok, act};
		do @(posedge clk); while (!s_tready);
		predicted = step_window(act, value, val_ok, idx);
		window_reports_due.push_back(typed ? typed_report : predicted);
	endtask

	function automatic void check_field(input string label, input logic [SAMPLE_W-1:0] want,
			input logic [SAMPLE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", label, want, got);
			mismatches++;
		end
	endfunction

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		window_report_t seen;
		window_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen.count  = m_tdata[COUNT_W-1:0];
			seen.low    = m_tdata[COUNT_W +: SAMPLE_W];
			seen.high   = m_tdata[COUNT_W + SAMPLE_W +: SAMPLE_W];
			seen.newest = m_tdata[COUNT_W + 2 * SAMPLE_W +: SAMPLE_W];
			seen.read   = m_tdata[COUNT_W + 3 * SAMPLE_W +: SAMPLE_W];
			if (window_reports_due.size() == 0) begin
				$error("result transaction with no expectation waiting");
				mismatches++;
			end else begin
				want = window_reports_due.pop_front();
				check_field("window_count", 32'(want.count), 32'(seen.count));
				check_field("window_min", want.low, seen.low);
				check_field("window_max", want.high, seen.high);
				check_field("newest_sample", want.newest, seen.newest);
				check_field("read_sample", want.read, seen.read);
			end
			reports_checked++;
		end
	end

	// Receiver: stall in phases of its own, with one long hold-off
	initial begin
		int mode;
		int span;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!long_hold_done && reports_checked >= 200) begin
				long_hold_done = 1'b1;
				repeat (LONG_HOLD) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end
			mode = $urandom_range(0, 3);
			span = (mode == 3) ? $urandom_range(1, 12) : $urandom_range(5, 60);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= 1'b0;
				endcase
			end
		end
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Reset, directed table, random episodes, drain
	initial begin
		int counted;
		int flavour;
		int run_len;
		int pick;
		logic [SAMPLE_W-1:0] ramp;
		logic [SAMPLE_W-1:0] stride;
		logic [SAMPLE_W-1:0] value;
		logic [INDEX_W-1:0] idx;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		reports_checked = 0;
		mismatches = 0;
		burst_left = 0;
		long_hold_done = 1'b0;
		ring_oldest = '0;
		ring_count = '0;
		ring_low = '0;
		ring_high = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[r])
			issue(directed_rows[r].act, directed_rows[r].value, directed_rows[r].val_ok,
				directed_rows[r].idx, directed_rows[r].typed, directed_rows[r].want);

		// Episodes of pushes that mostly fill and roll the window
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			flavour = $urandom_range(0, 4);
			run_len = $urandom_range(20, 160);
			ramp = $urandom;
			stride = $urandom_range(1, 1 << 16);
			if ($urandom_range(0, 2) == 0) begin
				issue(swmm_pkg::ACT_CLEAR, $urandom, 1'($urandom_range(0, 1)),
					INDEX_W'($urandom_range(0, 63)), 1'b0, '0);
				counted++;
			end
			for (int k = 0; k < run_len && counted < RANDOM_ITEMS; k++) begin
				case (flavour)
					0: value = $urandom;
					1: value = SAMPLE_W'($urandom_range(0, 6)) - 32'd3;
					2: begin
						ramp = ramp + stride;
						value = ramp;
					end
					3: begin
						ramp = ramp - stride;
						value = ramp;
					end
					default: begin
						case ($urandom_range(0, 4))
							0: value = 32'h8000_0000;
							1: value = 32'h7FFF_FFFF;
							2: value = 32'hFFFF_FFFF;
							3: value = 32'h0000_0001;
							default: value = '0;
						endcase
					end
				endcase
				idx = INDEX_W'($urandom_range(0, 63));
				pick = $urandom_range(0, 99);
				if (pick < 9) begin
					// mostly in range, sometimes anywhere
					if (ring_count != 0 && $urandom_range(0, 2) != 0)
						idx = INDEX_W'($urandom_range(0, ring_count - 1));
					issue(swmm_pkg::ACT_READ, value, 1'($urandom_range(0, 1)), idx,
						1'b0, '0);
					counted++;
				end else if (pick < 13) begin
					issue(swmm_pkg::ACT_PUSH, value, 1'b0, idx, 1'b0, '0);
				end else if (pick < 15) begin
					issue(ACT_SPARE, value, 1'($urandom_range(0, 1)), idx, 1'b0, '0);
				end else if (pick < 16) begin
					issue(swmm_pkg::ACT_CLEAR, value, 1'($urandom_range(0, 1)), idx,
						1'b0, '0);
					counted++;
				end else begin
					issue(swmm_pkg::ACT_PUSH, value, 1'b1, idx, 1'b0, '0);
					counted++;
				end
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		// Drain outstanding results, then let any stray output show up
		while (window_reports_due.size() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (mismatches == 0 && window_reports_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/swmm_pkg.sv
rtl/swmm_extreme_unit.sv
rtl/sliding_window_min_max_ring.sv
verif/sliding_window_min_max_ring_tb.sv
